// ----- rtl/apc_graphics_stream_splitter_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the graphics stream splitter
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef APC_GRAPHICS_STREAM_SPLITTER_CORE_ASSERT_SVH
`define APC_GRAPHICS_STREAM_SPLITTER_CORE_ASSERT_SVH

// Same-cycle implication
`define APC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define APC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/apc_gss_pkg.sv -----
// ----------------------------------------------------------------------------
// apc_gss_pkg
// Types, byte codes and decode functions of the graphics stream splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package apc_gss_pkg;

	// Parser mode
	typedef enum logic [2:0] {
		MODE_TEXT,
		MODE_ESC,
		MODE_ESC_US,
		MODE_HDR,
		MODE_PAY,
		MODE_PAY_ESC
	} mode_t;

	// Header token position
	typedef enum logic [1:0] {
		POS_KEY,
		POS_EQ,
		POS_VALUE,
		POS_REJECT
	} tok_pos_t;

	// Value scan phase
	typedef enum logic [1:0] {
		PH_LEAD,
		PH_SIGN,
		PH_DIGITS,
		PH_END
	} val_phase_t;

	// Result kinds
	localparam logic [1:0] KIND_TEXT  = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_FRAME = 2'd2;

	localparam int unsigned NKEYS = 9;

	// Byte codes
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_US    = 8'h5F; // '_'
	localparam logic [7:0] CH_G     = 8'h47; // 'G'
	localparam logic [7:0] CH_SEMI  = 8'h3B; // ';'
	localparam logic [7:0] CH_EQ    = 8'h3D; // '='
	localparam logic [7:0] CH_COMMA = 8'h2C; // ','
	localparam logic [7:0] CH_BSL   = 8'h5C; // '\'
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [3:0] SLOT_NONE = 4'd9;

	// Header key to slot, SLOT_NONE for unknown keys
	function automatic logic [3:0] key_slot(input logic [7:0] k);
		logic [3:0] s;
		unique case (k)
			8'h61:   s = 4'd0; // a
			8'h66:   s = 4'd1; // f
			8'h6D:   s = 4'd2; // m
			8'h69:   s = 4'd3; // i
			8'h71:   s = 4'd4; // q
			8'h63:   s = 4'd5; // c
			8'h72:   s = 4'd6; // r
			8'h58:   s = 4'd7; // X
			8'h59:   s = 4'd8; // Y
			default: s = SLOT_NONE;
		endcase
		return s;
	endfunction

	// Base64 symbol decode: {valid, 6-bit value}
	function automatic logic [6:0] b64_decode(input logic [7:0] c);
		logic [6:0] r;
		r = 7'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = {1'b1, 6'(c - 8'h41)};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r = {1'b1, 6'(c - 8'h61 + 8'd26)};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 6'(c - 8'h30 + 8'd52)};
		end else if (c == CH_PLUS) begin
			r = {1'b1, 6'd62};
		end else if (c == CH_SLASH) begin
			r = {1'b1, 6'd63};
		end
		return r;
	endfunction

endpackage

// ----- rtl/apc_graphics_stream_splitter_core.sv -----
// ----------------------------------------------------------------------------
// apc_graphics_stream_splitter_core
// Splits a terminal byte stream into text bytes and graphics frames.
// ----------------------------------------------------------------------------
// Input channel s_*: one terminal byte per request in s_tdata[7:0].
// Output channel m_*: one result per request. m_tuser is the kind (text,
// decoded payload byte, frame end), m_tdata holds the byte and, for frame end,
// the nine header values a f m i q c r X Y; m_tlast marks the final result
// caused by one input byte.
// A result is registered and shows on m_* in the cycle after its input byte is taken.
// Throughput: one byte per cycle while the receiver takes results. ESC followed
// by any byte other than '_' yields two results; the second one sits in a
// holding slot and the input pauses while it moves to the output register.
// Header and payload decode happen in the same cycle as the input request:
// one multiply-by-ten add and compare on the value accumulator is the longest
// path. s_tready depends on m_tready through the output register state.
// Reset clears the parser to text mode and zeroes all header values; there is
// no clearing pass. When the receiver stalls, the output register and the
// holding slot keep their results and s_tready drops until room frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "apc_graphics_stream_splitter_core_assert.svh"

module apc_graphics_stream_splitter_core
	import apc_gss_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] in_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [295:0] m_tdata,   // [7:0] data_byte, then hdr_a hdr_f hdr_m hdr_i
	                                // hdr_q hdr_c hdr_r hdr_x hdr_y, 32 bits each
	output logic [1:0]   m_tuser,   // [1:0] kind
	output logic         m_tlast    // last
);

	// Parser state
	mode_t       mode_q, mode_d;
	tok_pos_t    tok_pos_q, tok_pos_d;
	logic [7:0]  tok_key_q, tok_key_d;
	val_phase_t  ph_q, ph_d;
	logic        neg_q, neg_d;
	logic [31:0] mag_q, mag_d;
	logic        dig_q, dig_d;
	logic        ovf_q, ovf_d;
	logic [5:0]  bits_q, bits_d;
	logic [1:0]  pend_q, pend_d;   // held base64 bits divided by two
	logic [31:0] hv_q [NKEYS];
	logic [31:0] hv_d [NKEYS];

	// Output register and holding slot
	logic         a_valid_q;
	logic [1:0]   a_kind_q;
	logic [7:0]   a_data_q;
	logic         a_last_q;
	logic [287:0] a_hdr_q;
	logic         b_valid_q;
	logic [7:0]   b_data_q;

	logic        accept;
	logic        a_drain;
	logic [7:0]  in_b;

	// Results of the current request
	logic [1:0]  n_res;
	logic [1:0]  r0_kind;
	logic [7:0]  r0_data;
	logic        r0_last;

	// Base64 step
	logic [6:0]  b64_sym;
	logic [11:0] b64_cat;
	logic        b64_emit;
	logic [1:0]  b64_rem;
	logic [7:0]  b64_byte;
	logic [5:0]  b64_bits_n;
	logic [1:0]  b64_pend_n;

	// Value step
	logic        is_digit;
	logic        is_space;
	logic [35:0] acc_next;
	logic [35:0] acc_limit;

	// Token commit
	logic [3:0]  c_slot;
	logic        c_ok;
	logic [31:0] c_val;

	logic [287:0] hv_flat;

	assign in_b     = s_tdata;
	assign a_drain  = a_valid_q && m_tready;
	assign s_tready = !b_valid_q && (!a_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	assign m_tvalid = a_valid_q;
	assign m_tuser  = a_kind_q;
	assign m_tlast  = a_last_q;
	assign m_tdata  = {a_hdr_q, a_data_q};

	// Flatten header values, key a in the low word
	always_comb begin
		for (int k = 0; k < NKEYS; k++) begin
			hv_flat[32*k +: 32] = hv_q[k];
		end
	end

	// Decode one base64 symbol against the held bits
	always_comb begin
		b64_sym    = b64_decode(in_b);
		b64_cat    = {bits_q, b64_sym[5:0]};
		b64_emit   = b64_sym[6] && (pend_q != 2'd0);
		b64_rem    = pend_q - 2'd1;
		b64_byte   = 8'(b64_cat >> {b64_rem, 1'b0});
		b64_bits_n = bits_q;
		b64_pend_n = pend_q;
		if (b64_sym[6]) begin
			if (b64_emit) begin
				b64_bits_n = 6'(b64_cat & ((12'd1 << {b64_rem, 1'b0}) - 12'd1));
				b64_pend_n = b64_rem;
			end else begin
				b64_bits_n = b64_sym[5:0];
				b64_pend_n = 2'd3;
			end
		end
	end

	// Accumulate one decimal digit: mag * 10 + digit
	always_comb begin
		is_digit  = (in_b >= 8'h30) && (in_b <= 8'h39);
		is_space  = (in_b == CH_SPACE) || ((in_b >= 8'h09) && (in_b <= 8'h0D));
		acc_next  = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0}
			+ {32'd0, 4'(in_b - 8'h30)};
		acc_limit = neg_q ? 36'h0_8000_0000 : 36'h0_7FFF_FFFF;
	end

	// Commit the current token
	always_comb begin
		c_slot = key_slot(tok_key_q);
		c_ok   = (tok_pos_q == POS_VALUE) && dig_q && !ovf_q && (c_slot != SLOT_NONE);
		c_val  = neg_q ? (32'd0 - mag_q) : mag_q;
	end

	// Next mode
	always_comb begin
		mode_d = mode_q;
		unique case (mode_q)
			MODE_TEXT:    if (in_b == CH_ESC) mode_d = MODE_ESC;
			MODE_ESC:     mode_d = (in_b == CH_US) ? MODE_ESC_US : MODE_TEXT;
			MODE_ESC_US:  mode_d = (in_b == CH_G) ? MODE_HDR : MODE_TEXT;
			MODE_HDR:     if (in_b == CH_SEMI) mode_d = MODE_PAY;
			MODE_PAY:     if (in_b == CH_ESC) mode_d = MODE_PAY_ESC;
			MODE_PAY_ESC: mode_d = (in_b == CH_BSL) ? MODE_TEXT : MODE_PAY;
			default:      mode_d = MODE_TEXT;
		endcase
	end

	// Results per mode
	always_comb begin
		n_res   = 2'd0;
		r0_kind = KIND_TEXT;
		r0_data = in_b;
		r0_last = 1'b1;
		unique case (mode_q)
			MODE_TEXT: begin
				if (in_b != CH_ESC) n_res = 2'd1;
			end
			MODE_ESC: begin
				if (in_b != CH_US) begin
					n_res   = 2'd2;
					r0_data = CH_ESC;
					r0_last = 1'b0;
				end
			end
			MODE_PAY: begin
				if (in_b != CH_ESC && b64_emit) begin
					n_res   = 2'd1;
					r0_kind = KIND_DATA;
					r0_data = b64_byte;
				end
			end
			MODE_PAY_ESC: begin
				if (in_b == CH_BSL) begin
					n_res   = 2'd1;
					r0_kind = KIND_FRAME;
					r0_data = 8'd0;
				end else if (b64_emit) begin
					n_res   = 2'd1;
					r0_kind = KIND_DATA;
					r0_data = b64_byte;
				end
			end
			default: n_res = 2'd0;
		endcase
	end

	// Header and payload state updates
	always_comb begin
		tok_pos_d = tok_pos_q;
		tok_key_d = tok_key_q;
		ph_d      = ph_q;
		neg_d     = neg_q;
		mag_d     = mag_q;
		dig_d     = dig_q;
		ovf_d     = ovf_q;
		bits_d    = bits_q;
		pend_d    = pend_q;
		hv_d      = hv_q;
		unique case (mode_q)
			MODE_ESC_US: begin
				// frame start: clear header and base64 state
				if (in_b == CH_G) begin
					for (int k = 0; k < NKEYS; k++) begin
						hv_d[k] = 32'd0;
					end
					bits_d    = 6'd0;
					pend_d    = 2'd0;
					tok_pos_d = POS_KEY;
					tok_key_d = 8'd0;
					ph_d      = PH_LEAD;
					neg_d     = 1'b0;
					mag_d     = 32'd0;
					dig_d     = 1'b0;
					ovf_d     = 1'b0;
				end
			end
			MODE_HDR: begin
				if (in_b == CH_SEMI || in_b == CH_COMMA) begin
					if (c_ok) hv_d[c_slot] = c_val;
					tok_pos_d = POS_KEY;
					tok_key_d = 8'd0;
					ph_d      = PH_LEAD;
					neg_d     = 1'b0;
					mag_d     = 32'd0;
					dig_d     = 1'b0;
					ovf_d     = 1'b0;
				end else begin
					case (tok_pos_q)
						POS_KEY: begin
							tok_key_d = in_b;
							tok_pos_d = POS_EQ;
						end
						POS_EQ: tok_pos_d = (in_b == CH_EQ) ? POS_VALUE : POS_REJECT;
						POS_VALUE: begin
							// advance the value scan
							case (ph_q)
								PH_LEAD: begin
									if (is_space) begin
										ph_d = PH_LEAD;
									end else if (in_b == CH_PLUS || in_b == CH_MINUS) begin
										neg_d = (in_b == CH_MINUS);
										ph_d  = PH_SIGN;
									end else begin
										ph_d = is_digit ? PH_DIGITS : PH_END;
									end
								end
								PH_SIGN:   ph_d = is_digit ? PH_DIGITS : PH_END;
								PH_DIGITS: ph_d = is_digit ? PH_DIGITS : PH_END;
								default:   ph_d = PH_END;
							endcase
							if (ph_d == PH_DIGITS && is_digit) begin
								dig_d = 1'b1;
								if (ovf_q || acc_next > acc_limit) begin
									ovf_d = 1'b1;
								end else begin
									mag_d = acc_next[31:0];
								end
							end
						end
						default: tok_pos_d = POS_REJECT;
					endcase
				end
			end
			MODE_PAY: begin
				if (in_b != CH_ESC) begin
					bits_d = b64_bits_n;
					pend_d = b64_pend_n;
				end
			end
			MODE_PAY_ESC: begin
				if (in_b != CH_BSL) begin
					bits_d = b64_bits_n;
					pend_d = b64_pend_n;
				end
			end
			default: begin
				bits_d = bits_q;
			end
		endcase
	end

	// Parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_TEXT;
			tok_pos_q <= POS_KEY;
			tok_key_q <= 8'd0;
			ph_q      <= PH_LEAD;
			neg_q     <= 1'b0;
			mag_q     <= 32'd0;
			dig_q     <= 1'b0;
			ovf_q     <= 1'b0;
			bits_q    <= 6'd0;
			pend_q    <= 2'd0;
			for (int k = 0; k < NKEYS; k++) begin
				hv_q[k] <= 32'd0;
			end
		end else if (accept) begin
			mode_q    <= mode_d;
			tok_pos_q <= tok_pos_d;
			tok_key_q <= tok_key_d;
			ph_q      <= ph_d;
			neg_q     <= neg_d;
			mag_q     <= mag_d;
			dig_q     <= dig_d;
			ovf_q     <= ovf_d;
			bits_q    <= bits_d;
			pend_q    <= pend_d;
			hv_q      <= hv_d;
		end
	end

	// Output register and holding slot control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_valid_q <= 1'b0;
			b_valid_q <= 1'b0;
		end else if (accept && n_res != 2'd0) begin
			a_valid_q <= 1'b1;
			b_valid_q <= (n_res == 2'd2);
		end else if (a_drain) begin
			a_valid_q <= b_valid_q;
			b_valid_q <= 1'b0;
		end
	end

	// Output register and holding slot payload
	always_ff @(posedge clk) begin
		if (accept && n_res != 2'd0) begin
			a_kind_q <= r0_kind;
			a_data_q <= r0_data;
			a_last_q <= r0_last;
			a_hdr_q  <= (r0_kind == KIND_FRAME) ? hv_flat : 288'd0;
			b_data_q <= in_b;
		end else if (a_drain && b_valid_q) begin
			// move the held text byte up
			a_kind_q <= KIND_TEXT;
			a_data_q <= b_data_q;
			a_last_q <= 1'b1;
			a_hdr_q  <= 288'd0;
		end
	end

	// Checks
	`APC_ASSERT_SAME(a_slot_order, b_valid_q, a_valid_q,
		"holding slot filled while output register empty")
	`APC_ASSERT_SAME(a_hdr_zero, m_tvalid && (m_tuser != KIND_FRAME), m_tdata[295:8] == 288'd0,
		"header values present on a non-frame result")
	`APC_ASSERT_NEXT(a_esc_pair, accept && (mode_q == MODE_ESC) && (in_b != CH_US),
		a_valid_q && b_valid_q && !m_tlast && (m_tdata[7:0] == CH_ESC),
		"escape pair did not produce two text results")

endmodule
